### hw/rtl/llc_frame_header_parser_assert.svh
// Assertion macros for the LLC header parser checker.
`ifndef LLC_FRAME_HEADER_PARSER_ASSERT_SVH
`define LLC_FRAME_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LLCFHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("llcfhp assertion failed");

// Next-cycle implication, disabled while in reset.
`define LLCFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("llcfhp assertion failed");

`endif

### hw/rtl/llcfhp_pkg.sv
// ----------------------------------------------------------------------------
// llcfhp_pkg
// Types, constants and decode functions for the LLC frame header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package llcfhp_pkg;

    localparam int HDR_BYTES = 18;
    localparam int HDR_IDX_W = 5;
    localparam int SAP_COUNT = 22;

    localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd1500;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    // Frame kinds
    localparam logic [1:0] KIND_INFO = 2'd0;
    localparam logic [1:0] KIND_SUP  = 2'd1;
    localparam logic [1:0] KIND_UNN  = 2'd2;

    // Control byte low bits
    localparam logic [1:0] CTL_SUP = 2'b01;
    localparam logic [1:0] CTL_UNN = 2'b11;

    // Command codes
    localparam logic [4:0] CMD_NONE  = 5'd0;
    localparam logic [4:0] CMD_SNRM  = 5'd1;
    localparam logic [4:0] CMD_SNRME = 5'd2;
    localparam logic [4:0] CMD_SARM  = 5'd3;
    localparam logic [4:0] CMD_SARME = 5'd4;
    localparam logic [4:0] CMD_SABM  = 5'd5;
    localparam logic [4:0] CMD_SABME = 5'd6;
    localparam logic [4:0] CMD_SIM   = 5'd7;
    localparam logic [4:0] CMD_DISC  = 5'd8;
    localparam logic [4:0] CMD_UP    = 5'd9;
    localparam logic [4:0] CMD_RSET  = 5'd10;
    localparam logic [4:0] CMD_UA    = 5'd11;
    localparam logic [4:0] CMD_DM    = 5'd12;
    localparam logic [4:0] CMD_RD    = 5'd13;
    localparam logic [4:0] CMD_UI    = 5'd14;
    localparam logic [4:0] CMD_XID   = 5'd15;
    localparam logic [4:0] CMD_TEST  = 5'd16;
    localparam logic [4:0] CMD_RR    = 5'd17;

    // Unnumbered control patterns after masking
    localparam logic [7:0] U_MASK  = 8'hEC;
    localparam logic [7:0] U_SNRM  = 8'h80;
    localparam logic [7:0] U_SNRME = 8'hCC;
    localparam logic [7:0] U_SARM  = 8'h0C;
    localparam logic [7:0] U_SARME = 8'h4C;
    localparam logic [7:0] U_SABM  = 8'h2C;
    localparam logic [7:0] U_SABME = 8'h6C;
    localparam logic [7:0] U_SIM   = 8'h04;
    localparam logic [7:0] U_DISC  = 8'h40;
    localparam logic [7:0] U_UP    = 8'h20;
    localparam logic [7:0] U_RSET  = 8'h8C;
    localparam logic [7:0] U_UA    = 8'h60;
    localparam logic [7:0] U_DM    = 8'h0C;
    localparam logic [7:0] U_RD    = 8'h40;
    localparam logic [7:0] U_UI    = 8'h00;
    localparam logic [7:0] U_XID   = 8'hAC;
    localparam logic [7:0] U_TEST  = 8'hE0;

    localparam logic [7:0] SAP_TABLE [SAP_COUNT] = '{
        8'h00, 8'h02, 8'h04, 8'h06, 8'h08, 8'h0E, 8'h18, 8'h42, 8'h4E, 8'h7E, 8'h80,
        8'h86, 8'h8E, 8'h98, 8'hBC, 8'hAA, 8'hE0, 8'hF0, 8'hF4, 8'hF8, 8'hFA, 8'hFE
    };

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] src_mac;
        logic [15:0] length_field;
        logic [4:0]  dsap_class;
        logic        group_address;
        logic [4:0]  ssap_class;
        logic        is_response;
        logic [1:0]  frame_kind;
        logic [6:0]  send_seq;
        logic [6:0]  recv_seq;
        logic [4:0]  command_code;
        logic        short_frame;
    } t_llc_result;

    // Table entries are distinct, so at most one matches.
    function automatic logic [4:0] sap_class(input logic [7:0] sap);
        logic [4:0] cls;
        cls = 5'd0;
        for (int i = 0; i < SAP_COUNT; i++) begin
            if (SAP_TABLE[i] == {sap[7:1], 1'b0}) begin
                cls = 5'(i + 1);
            end
        end
        return cls;
    endfunction

    function automatic logic [4:0] unnumbered_code(input logic [7:0] ctl, input logic rsp);
        logic [7:0] m;
        logic [4:0] code;
        m = ctl & U_MASK;
        case (m)
            U_UI:    code = CMD_UI;
            U_XID:   code = CMD_XID;
            U_TEST:  code = CMD_TEST;
            default: code = CMD_NONE;
        endcase
        if (!rsp) begin
            case (m)
                U_SNRM:  code = CMD_SNRM;
                U_SNRME: code = CMD_SNRME;
                U_SARM:  code = CMD_SARM;
                U_SARME: code = CMD_SARME;
                U_SABM:  code = CMD_SABM;
                U_SABME: code = CMD_SABME;
                U_SIM:   code = CMD_SIM;
                U_DISC:  code = CMD_DISC;
                U_UP:    code = CMD_UP;
                U_RSET:  code = CMD_RSET;
                default: ;
            endcase
        end else begin
            case (m)
                U_UA:    code = CMD_UA;
                U_DM:    code = CMD_DM;
                U_RD:    code = CMD_RD;
                default: ;
            endcase
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/llcfhp_if.sv
// ----------------------------------------------------------------------------
// llcfhp channel interfaces
// Byte input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface llcfhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface llcfhp_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] length_field;
    logic [4:0]  dsap_class;
    logic        group_address;
    logic [4:0]  ssap_class;
    logic        is_response;
    logic [1:0]  frame_kind;
    logic [6:0]  send_seq;
    logic [6:0]  recv_seq;
    logic [4:0]  command_code;
    logic        short_frame;

    modport source (output valid, output dest_mac, output src_mac, output length_field,
                    output dsap_class, output group_address, output ssap_class,
                    output is_response, output frame_kind, output send_seq,
                    output recv_seq, output command_code, output short_frame,
                    input ready);
    modport sink   (input valid, input dest_mac, input src_mac, input length_field,
                    input dsap_class, input group_address, input ssap_class,
                    input is_response, input frame_kind, input send_seq,
                    input recv_seq, input command_code, input short_frame,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/llc_frame_header_parser.sv
// ----------------------------------------------------------------------------
// llc_frame_header_parser
// Byte-stream IEEE 802.2 LLC header capture and decode.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte   : one frame byte per transfer, wire order, last_byte on the final
//              byte. A byte is taken every cycle while i_byte.ready is high.
//   o_result : one decoded header per frame whose length field is below the
//              length limit; frames at or above the limit are dropped silently.
//   i_cfg_we / i_cfg_wdata : writes the 16-bit length limit; write only while
//              no frame is in flight and no result is pending.
//   Throughput: one byte per cycle, except a final byte held by a full slot.
//   Latency: the result is valid the cycle after the last-byte transfer; the
//   decode sits between the header store and the result register.
//   Reset (synchronous, active low): byte count and header store cleared,
//   length limit returns to 1500, result register empty.
//   Receiver stall: the result register holds its contents. Bytes that are not
//   final are still taken; i_byte.ready drops only while a result waits and
//   the receiver is not taking it.
// ----------------------------------------------------------------------------
`default_nettype none

module llc_frame_header_parser #(
    parameter int MAX_FRAME_BYTES = 1514
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    llcfhp_byte_if.sink       i_byte,
    llcfhp_result_if.source   o_result,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata
);
    import llcfhp_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // Header store and saturating byte count
    t_hdr              r_hdr;
    t_hdr              n_hdr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [15:0]       r_length_limit;

    // Result register
    t_llc_result       r_res;
    logic              r_out_valid;

    t_llc_result       dec_res;
    logic              dec_emit;
    logic              short_frame;
    logic              in_xfer;
    logic              last_xfer;

    // Bytes may still be taken when the result slot is busy, but a final byte
    // needs the slot free or emptying this cycle.
    assign i_byte.ready = !r_out_valid || o_result.ready || !i_byte.last_byte;
    assign in_xfer      = i_byte.valid && i_byte.ready;
    assign last_xfer    = in_xfer && i_byte.last_byte;

    // Header with the current byte written in at its place, if still inside
    // the first 18 bytes.
    always_comb begin
        n_hdr = r_hdr;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (r_count == CNT_W'(i)) begin
                n_hdr[i] = i_byte.frame_byte;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (r_count < CNT_W'(MAX_FRAME_BYTES)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // Count after this byte is below 18
    assign short_frame = (r_count < CNT_W'(HDR_BYTES - 1));

    llcfhp_decode u_decode (
        .i_hdr          (n_hdr),
        .i_short        (short_frame),
        .i_length_limit (r_length_limit),
        .o_res          (dec_res),
        .o_emit         (dec_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= '0;
            r_count <= '0;
        end else if (in_xfer) begin
            if (i_byte.last_byte) begin
                r_hdr   <= '0;
                r_count <= '0;
            end else begin
                r_hdr   <= n_hdr;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_limit <= LENGTH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_length_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_xfer) begin
            r_out_valid <= dec_emit;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_xfer && dec_emit) begin
            r_res <= dec_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.dest_mac      = r_res.dest_mac;
    assign o_result.src_mac       = r_res.src_mac;
    assign o_result.length_field  = r_res.length_field;
    assign o_result.dsap_class    = r_res.dsap_class;
    assign o_result.group_address = r_res.group_address;
    assign o_result.ssap_class    = r_res.ssap_class;
    assign o_result.is_response   = r_res.is_response;
    assign o_result.frame_kind    = r_res.frame_kind;
    assign o_result.send_seq      = r_res.send_seq;
    assign o_result.recv_seq      = r_res.recv_seq;
    assign o_result.command_code  = r_res.command_code;
    assign o_result.short_frame   = r_res.short_frame;

endmodule

`default_nettype wire

### hw/rtl/llcfhp_decode.sv
// ----------------------------------------------------------------------------
// llcfhp_decode
// Combinational decode of an 18-byte LLC header into result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module llcfhp_decode (
    input  wire llcfhp_pkg::t_hdr        i_hdr,
    input  wire logic                    i_short,
    input  wire logic [15:0]             i_length_limit,
    output llcfhp_pkg::t_llc_result      o_res,
    output logic                         o_emit
);
    import llcfhp_pkg::*;

    logic [7:0] dsap, ssap, c1, c2;

    assign dsap = i_hdr[14];
    assign ssap = i_hdr[15];
    assign c1   = i_hdr[16];
    assign c2   = i_hdr[17];

    always_comb begin
        o_res               = '0;
        o_res.dest_mac      = {i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3], i_hdr[4], i_hdr[5]};
        o_res.src_mac       = {i_hdr[6], i_hdr[7], i_hdr[8], i_hdr[9], i_hdr[10], i_hdr[11]};
        o_res.length_field  = {i_hdr[12], i_hdr[13]};
        o_res.dsap_class    = sap_class(dsap);
        o_res.group_address = dsap[0];
        o_res.ssap_class    = sap_class(ssap);
        o_res.is_response   = ssap[0];
        o_res.short_frame   = i_short;
        case (c1[1:0])
            CTL_SUP: begin
                o_res.frame_kind   = KIND_SUP;
                o_res.recv_seq     = c2[7:1];
                o_res.command_code = CMD_RR + {3'b000, c1[3:2]};
            end
            CTL_UNN: begin
                o_res.frame_kind   = KIND_UNN;
                o_res.command_code = unnumbered_code(c1, ssap[0]);
            end
            default: begin
                o_res.frame_kind = KIND_INFO;
                o_res.send_seq   = c1[7:1];
                o_res.recv_seq   = c2[7:1];
            end
        endcase
    end

    assign o_emit = (o_res.length_field < i_length_limit);

endmodule

`default_nettype wire

### hw/rtl/llcfhp_checker.sv
// ----------------------------------------------------------------------------
// llcfhp_checker
// Port-level checks for the LLC header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "llc_frame_header_parser_assert.svh"

module llcfhp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_last,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [47:0] i_out_dest_mac,
    input wire logic [1:0]  i_out_kind,
    input wire logic [4:0]  i_out_code
);

    // Pending result must hold while stalled
    `LLCFHP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_dest_mac))

    // A non-final byte never raises a result
    `LLCFHP_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, (!i_in_valid || !i_in_ready || !i_in_last) && (!i_out_valid || i_out_ready), !i_out_valid)

    // Empty result slot never blocks input
    `LLCFHP_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // Decoded kind and command stay in their code ranges
    `LLCFHP_ASSERT_NOW(a_codes_legal, i_clk, i_rst_n, i_out_valid, (i_out_kind != 2'd3) && (i_out_code <= 5'd20))

endmodule

bind llc_frame_header_parser llcfhp_checker u_llcfhp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_byte.valid),
    .i_in_ready     (i_byte.ready),
    .i_in_last      (i_byte.last_byte),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_dest_mac (o_result.dest_mac),
    .i_out_kind     (o_result.frame_kind),
    .i_out_code     (o_result.command_code)
);

`default_nettype wire

### tb/llc_frame_header_parser_tb.sv
// ----------------------------------------------------------------------------
// llc_frame_header_parser_tb
// Self-checking bench for the LLC header parser. Frames are streamed into the
// byte channel one transfer at a time. Each byte is fed to a local decoder as
// the DUT takes it, and every decoded header below the length limit is queued
// as a prediction. The result channel is compared field by field against those
// predictions. The length limit is changed between phases while the parser is idle.
// ----------------------------------------------------------------------------
module llc_frame_header_parser_tb;
    import llcfhp_pkg::*;

    localparam int MAX_FRAME   = 1514;
    localparam int LONG_FRAME  = HDR_BYTES + 100;
    localparam int HOLD_CYCLES = 300;   // long receiver stall, fills the parser
    localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE      = 4;     // result lands the cycle after the last byte

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    // Unnumbered patterns: SNRM..RSET are commands, UA/DM/RD responses,
    // UI/XID/TEST either
    localparam logic [7:0] U_PATTERNS [16] = '{
        U_SNRM, U_SNRME, U_SARM, U_SARME, U_SABM, U_SABME, U_SIM, U_DISC,
        U_UP, U_RSET, U_UA, U_DM, U_RD, U_UI, U_XID, U_TEST
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    llcfhp_byte_if   byte_ch ();
    llcfhp_result_if result_ch ();

    llc_frame_header_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Stimulus and prediction state
    t_wire_byte  bytes_to_send [$];
    t_llc_result headers_due [$];
    t_hdr        rx_hdr       = '0;
    int unsigned rx_count     = 0;
    logic [15:0] limit_now    = LENGTH_LIMIT_RESET;
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned fault_count  = 0;
    bit          idling_on    = 1'b1;
    int unsigned hold_asks    = 0;
    int unsigned hold_served  = 0;
    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_hold      = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // SAP class: one-based index into the known list, bit 0 ignored, 0 if not listed
    function automatic logic [4:0] sap_code(input logic [7:0] sap);
        logic [4:0] code;
        code = 5'd0;
        for (int i = 0; i < SAP_COUNT; i++) begin
            if (SAP_TABLE[i] == {sap[7:1], 1'b0}) begin
                code = 5'(i + 1);
            end
        end
        return code;
    endfunction

    // U frame command from masked control byte; C/R bit picks the table
    function automatic logic [4:0] u_command(input logic [7:0] ctl, input logic rsp);
        logic [7:0] m;
        m = ctl & U_MASK;
        if (!rsp) begin
            case (m)
                U_SNRM:  return CMD_SNRM;
                U_SNRME: return CMD_SNRME;
                U_SARM:  return CMD_SARM;
                U_SARME: return CMD_SARME;
                U_SABM:  return CMD_SABM;
                U_SABME: return CMD_SABME;
                U_SIM:   return CMD_SIM;
                U_DISC:  return CMD_DISC;
                U_UP:    return CMD_UP;
                U_RSET:  return CMD_RSET;
                default: ;
            endcase
        end else begin
            case (m)
                U_UA:    return CMD_UA;
                U_DM:    return CMD_DM;
                U_RD:    return CMD_RD;
                default: ;
            endcase
        end
        case (m)
            U_UI:    return CMD_UI;
            U_XID:   return CMD_XID;
            U_TEST:  return CMD_TEST;
            default: return CMD_NONE;
        endcase
    endfunction

    task automatic compare_field(input string fname, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got) begin
            fault_count++;
            $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    // Queue one frame: header bytes first, anything past the header random
    task automatic send_frame(input t_hdr hdr, input int unsigned n_bytes);
        t_wire_byte wb;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            wb.data = (i < HDR_BYTES) ? hdr[i] : 8'($urandom);
            wb.last = (i == n_bytes - 1);
            bytes_to_send.push_back(wb);
        end
        bytes_queued += n_bytes;
    endtask

    // Mostly well-formed frames with lengths, SAPs and control bytes steered
    // towards the interesting decodes; a share of short and odd frames too
    task automatic send_random_frames(input int unsigned budget);
        t_hdr        h;
        int unsigned first_no;
        int unsigned pick;
        int unsigned n_bytes;
        logic [15:0] len;
        first_no = bytes_queued;
        while (bytes_queued - first_no < budget) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                h[i] = 8'($urandom);
            end
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                h[5:0] = '1;        // broadcast destination
            end else if (pick == 1) begin
                h[11:0] = '0;
            end else if (pick == 2) begin
                h[11:0] = '1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = (limit_now == 16'd0) ? 16'($urandom)
                                               : 16'($urandom_range(0, limit_now - 1));
                end
                6:       len = limit_now - 16'd1;   // just under the limit
                7:       len = limit_now;           // at the limit, dropped
                8:       len = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: len = 16'($urandom);
            endcase
            {h[12], h[13]} = len;
            if ($urandom_range(0, 3) != 0) begin
                h[14] = SAP_TABLE[$urandom_range(0, SAP_COUNT - 1)] | 8'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 3) != 0) begin
                h[15] = SAP_TABLE[$urandom_range(0, SAP_COUNT - 1)] | 8'($urandom_range(0, 1));
            end
            case ($urandom_range(0, 3))
                0: h[16][0]   = 1'b0;      // information
                1: h[16][1:0] = CTL_SUP;
                2: h[16][1:0] = CTL_UNN;   // arbitrary U control, often unmatched
                default: begin
                    // known U pattern, P/F bit kept random, C/R bit to suit
                    pick  = $urandom_range(0, 15);
                    h[16] = U_PATTERNS[pick] | {3'b000, h[16][4], 4'b0011};
                    if (pick >= 10 && pick <= 12) begin
                        h[15][0] = 1'b1;
                    end else if (pick < 10) begin
                        h[15][0] = 1'b0;
                    end
                end
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2: n_bytes = $urandom_range(1, HDR_BYTES - 1);
                3:       n_bytes = $urandom_range(41, 90);
                default: n_bytes = $urandom_range(HDR_BYTES, 40);
            endcase
            send_frame(h, n_bytes);
        end
    endtask

    // Wait until every queued byte has gone in and every result has come out
    task automatic drain();
        do @(negedge i_clk); while (bytes_taken != bytes_queued || headers_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_now    = value;
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: presents the next queued byte once the current one has
    // transferred, with random idle bursts, while idling is on, between any two bytes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            tx_gap        <= 0;
        end else if (!byte_ch.valid || byte_ch.ready) begin
            if (tx_gap != 0) begin
                byte_ch.valid <= 1'b0;
                tx_gap        <= tx_gap - 1;
            end else if (bytes_to_send.size() != 0) begin
                byte_ch.valid      <= 1'b1;
                byte_ch.frame_byte <= bytes_to_send[0].data;
                byte_ch.last_byte  <= bytes_to_send[0].last;
                bytes_to_send.delete(0);
                if (idling_on && $urandom_range(0, 24) == 0) begin
                    tx_gap <= $urandom_range(1, 19);
                end
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Header decoder: follows the parser byte by byte. The first 18 bytes are
    // kept, the count saturates on long frames, and the last byte decodes
    // the header (missing bytes of a short frame read as zero). A result is
    // only predicted when the length field is below the current limit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : decode_frames
        t_llc_result hdr_out;
        logic [7:0]  c1;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            bytes_taken++;
            if (rx_count < HDR_BYTES) begin
                rx_hdr[rx_count] = byte_ch.frame_byte;
            end
            if (rx_count < MAX_FRAME) begin
                rx_count++;
            end
            if (byte_ch.last_byte) begin
                c1                    = rx_hdr[16];
                hdr_out               = '0;
                hdr_out.dest_mac      = {rx_hdr[0], rx_hdr[1], rx_hdr[2],
                                         rx_hdr[3], rx_hdr[4], rx_hdr[5]};
                hdr_out.src_mac       = {rx_hdr[6], rx_hdr[7], rx_hdr[8],
                                         rx_hdr[9], rx_hdr[10], rx_hdr[11]};
                hdr_out.length_field  = {rx_hdr[12], rx_hdr[13]};
                hdr_out.dsap_class    = sap_code(rx_hdr[14]);
                hdr_out.group_address = rx_hdr[14][0];
                hdr_out.ssap_class    = sap_code(rx_hdr[15]);
                hdr_out.is_response   = rx_hdr[15][0];
                hdr_out.short_frame   = (rx_count < HDR_BYTES);
                case (c1[1:0])
                    CTL_SUP: begin
                        hdr_out.frame_kind   = KIND_SUP;
                        hdr_out.recv_seq     = rx_hdr[17][7:1];
                        hdr_out.command_code = CMD_RR + 5'(c1[3:2]);
                    end
                    CTL_UNN: begin
                        hdr_out.frame_kind   = KIND_UNN;
                        hdr_out.command_code = u_command(c1, rx_hdr[15][0]);
                    end
                    default: begin
                        hdr_out.frame_kind = KIND_INFO;
                        hdr_out.send_seq   = c1[7:1];
                        hdr_out.recv_seq   = rx_hdr[17][7:1];
                    end
                endcase
                if (hdr_out.length_field < limit_now) begin
                    headers_due.push_back(hdr_out);
                end
                rx_count = 0;
                rx_hdr   = '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each result transfer against the oldest
    // prediction and drives ready, with idle bursts and the long hold
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_llc_result got;
        t_llc_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got = {result_ch.dest_mac, result_ch.src_mac, result_ch.length_field,
                       result_ch.dsap_class, result_ch.group_address,
                       result_ch.ssap_class, result_ch.is_response, result_ch.frame_kind,
                       result_ch.send_seq, result_ch.recv_seq, result_ch.command_code,
                       result_ch.short_frame};
                if (headers_due.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = headers_due.pop_front();
                    compare_field("dest_mac",      want.dest_mac,      got.dest_mac);
                    compare_field("src_mac",       want.src_mac,       got.src_mac);
                    compare_field("length_field",  want.length_field,  got.length_field);
                    compare_field("dsap_class",    want.dsap_class,    got.dsap_class);
                    compare_field("group_address", want.group_address, got.group_address);
                    compare_field("ssap_class",    want.ssap_class,    got.ssap_class);
                    compare_field("is_response",   want.is_response,   got.is_response);
                    compare_field("frame_kind",    want.frame_kind,    got.frame_kind);
                    compare_field("send_seq",      want.send_seq,      got.send_seq);
                    compare_field("recv_seq",      want.recv_seq,      got.recv_seq);
                    compare_field("command_code",  want.command_code,  got.command_code);
                    compare_field("short_frame",   want.short_frame,   got.short_frame);
                end
            end
            if (hold_served != hold_asks) begin
                hold_served      = hold_asks;
                rx_hold          = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end else if (rx_hold != 0) begin
                rx_hold--;
                result_ch.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (idling_on && $urandom_range(0, 19) == 0) begin
                    rx_gap = $urandom_range(1, 19);
                end
            end
        end
    end

    // Watchdog: no transfer on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run_phases
        t_hdr hdr;
        byte_ch.valid      = 1'b0;
        byte_ch.frame_byte = '0;
        byte_ch.last_byte  = 1'b0;
        result_ch.ready    = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Limit at its reset value. A frame of one byte decodes from zeros and
        // is flagged short; an all-ones header with a zero length drives both MAC
        // addresses and both SAP bytes to all ones.
        hdr = '0;
        send_frame(hdr, 1);
        hdr = '1;
        {hdr[12], hdr[13]} = 16'h0000;
        send_frame(hdr, HDR_BYTES);
        send_random_frames(260);

        // Limit of zero: every frame is dropped, parser must still clear
        drain();
        write_limit(16'h0000);
        send_random_frames(100);

        // Limit at maximum. Receiver holds off while frames keep coming, so
        // the parser backs up and stalls its input.
        drain();
        write_limit(16'hFFFF);
        send_random_frames(220);
        @(negedge i_clk);
        hold_asks++;
        // Long frame: bytes past the header are counted, not stored, and the
        // frame ends only at its last byte
        hdr = '0;
        hdr[5:0] = '1;
        {hdr[12], hdr[13]} = 16'd46;
        hdr[14] = 8'h42;
        hdr[15] = 8'h42;
        hdr[16] = U_SABME | 8'h13;
        send_frame(hdr, LONG_FRAME);
        // Sender stops until the result side has caught up completely
        drain();
        send_random_frames(220);

        drain();
        write_limit(16'($urandom_range(1, 65534)));
        send_random_frames(300);

        // Back to the standard limit, full rate on both sides
        drain();
        write_limit(LENGTH_LIMIT_RESET);
        idling_on = 1'b0;
        send_random_frames(320);
        drain();

        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
